### sv/text_console_cursor_engine_defines.svh
// Assertion macros for the text console cursor engine.
// Included by the top level; depends on clk and rst_n in the including module.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH
`ifndef ASSERT_OFF
`define TCCE_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define TCCE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define TCCE_ASSERT(lbl, cond, msg)
`define TCCE_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

### sv/tcce_pkg.sv
// Types and constants of the text console cursor engine.
// No dependencies; imported by the top level.
package tcce_pkg;

  localparam int TEXT_COLUMNS_DEF = 21;
  localparam int TEXT_ROWS_DEF    = 8;
  localparam int GLYPH_WIDTH_DEF  = 6;

  // Control characters.
  localparam logic [7:0] CHAR_NUL = 8'd0;
  localparam logic [7:0] CHAR_TAB = 8'd9;
  localparam logic [7:0] CHAR_LF  = 8'd10;
  localparam logic [7:0] CHAR_CR  = 8'd13;

  // Configuration register indexes.
  localparam logic [1:0] CFG_IDX_CONTINUOUS   = 2'd0;
  localparam logic [1:0] CFG_IDX_START_COLUMN = 2'd1;
  localparam logic [1:0] CFG_IDX_START_ROW    = 2'd2;

  typedef struct packed {
    logic [7:0] char_code;
    logic       string_start;
  } tcce_in_t;

  typedef struct packed {
    logic        draw_valid;
    logic [7:0]  scroll_lines;
    logic [6:0]  pixel_column;
    logic [2:0]  page_row;
    logic [7:0]  glyph_code;
    logic [4:0]  cursor_column;
    logic [15:0] cursor_row;
  } tcce_out_t;

endpackage

### sv/text_console_cursor_engine.sv
// Latency: a request's result is valid in the cycle after it is accepted.
// Throughput: one request per cycle while out_ready is high; the cursor state and
// the output register are both updated in the accepting cycle, so the output
// register alone sets the rate, and it is refilled in the same cycle it is read.
// Reset (rst_n low, synchronous): cursor at column 0, row 0, newline allowed,
// no pending scrolls, all configuration registers 0, output empty.
`include "text_console_cursor_engine_defines.svh"

module text_console_cursor_engine
  import tcce_pkg::*;
#(
  parameter int TEXT_COLUMNS = TEXT_COLUMNS_DEF,
  parameter int TEXT_ROWS    = TEXT_ROWS_DEF,
  parameter int GLYPH_WIDTH  = GLYPH_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  tcce_in_t  in_payload,
  output logic      out_valid,
  input  logic      out_ready,
  output tcce_out_t out_payload,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [4:0] cfg_data
);

  localparam logic [4:0]  LAST_COL = 5'(TEXT_COLUMNS - 1);
  localparam logic [5:0]  NUM_COLS = 6'(TEXT_COLUMNS);
  localparam logic [15:0] LAST_ROW = 16'(TEXT_ROWS - 1);
  localparam logic [7:0]  GLYPH_W  = 8'(GLYPH_WIDTH);

  logic        continuous_r;
  logic [4:0]  start_col_r;
  logic [2:0]  start_row_r;

  logic [4:0]  col_r, col_nxt;
  logic [15:0] row_r, row_nxt;
  logic        nl_ok_r, nl_ok_nxt;
  logic [7:0]  pend_r, pend_nxt;

  logic        out_valid_r;
  tcce_out_t   out_r, out_nxt;

  logic        in_fire;
  logic        load;
  logic        is_draw;
  logic [4:0]  col0;
  logic [15:0] row0;
  logic [15:0] row_dn;
  logic        row_dn_past;
  logic [7:0]  pend_dn;
  logic [5:0]  tab_col;
  logic [5:0]  adv_col;
  logic [7:0]  pix_full;
  logic [15:0] page_full;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_payload = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      continuous_r <= 1'b0;
      start_col_r  <= 5'd0;
      start_row_r  <= 3'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_IDX_CONTINUOUS:   continuous_r <= cfg_data[0];
        CFG_IDX_START_COLUMN: start_col_r  <= cfg_data;
        CFG_IDX_START_ROW:    start_row_r  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Cursor as seen by this character, after a possible string-start reload.
  assign load = in_payload.string_start && !continuous_r;
  assign col0 = !load ? col_r : ((start_col_r > LAST_COL) ? LAST_COL : start_col_r);
  assign row0 = load ? {13'd0, start_row_r} : row_r;

  // One row down, saturating; a move below the last row counts a scroll.
  assign row_dn      = (row0 == 16'hFFFF) ? row0 : row0 + 16'd1;
  assign row_dn_past = row_dn > LAST_ROW;
  assign pend_dn     = (row_dn_past && pend_r != 8'hFF) ? pend_r + 8'd1 : pend_r;

  assign tab_col   = {({1'b0, col0[4:2]} + 4'd1), 2'b00};
  assign adv_col   = {1'b0, col0} + 6'd1;
  assign pix_full  = {3'd0, col0} * GLYPH_W;
  assign page_full = (row0 > LAST_ROW) ? LAST_ROW : row0;

  always_comb begin
    col_nxt   = col0;
    row_nxt   = row0;
    nl_ok_nxt = nl_ok_r;
    pend_nxt  = pend_r;
    is_draw   = 1'b0;
    unique case (in_payload.char_code)
      CHAR_NUL: ;
      CHAR_CR:  col_nxt = 5'd0;
      CHAR_LF: begin
        nl_ok_nxt = 1'b1;
        if (nl_ok_r) begin
          row_nxt  = row_dn;
          pend_nxt = pend_dn;
        end
      end
      CHAR_TAB: begin
        nl_ok_nxt = 1'b1;
        if (tab_col >= {1'b0, LAST_COL}) begin
          col_nxt  = 5'd0;
          row_nxt  = row_dn;
          pend_nxt = pend_dn;
        end else begin
          col_nxt = tab_col[4:0];
        end
      end
      default: begin
        // Pending scrolls go out with the draw; a wrap starts a fresh count.
        is_draw   = 1'b1;
        nl_ok_nxt = 1'b1;
        pend_nxt  = 8'd0;
        if (adv_col >= NUM_COLS) begin
          col_nxt   = 5'd0;
          nl_ok_nxt = 1'b0;
          row_nxt   = row_dn;
          pend_nxt  = {7'd0, row_dn_past};
        end else begin
          col_nxt = adv_col[4:0];
        end
      end
    endcase

    out_nxt.draw_valid    = is_draw;
    out_nxt.scroll_lines  = is_draw ? pend_r : 8'd0;
    out_nxt.pixel_column  = is_draw ? pix_full[6:0] : 7'd0;
    out_nxt.page_row      = is_draw ? page_full[2:0] : 3'd0;
    out_nxt.glyph_code    = is_draw ? in_payload.char_code : 8'd0;
    out_nxt.cursor_column = col_nxt;
    out_nxt.cursor_row    = row_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= 5'd0;
      row_r       <= 16'd0;
      nl_ok_r     <= 1'b1;
      pend_r      <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        col_r       <= col_nxt;
        row_r       <= row_nxt;
        nl_ok_r     <= nl_ok_nxt;
        pend_r      <= pend_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_r <= out_nxt;
    end
  end

  `TCCE_ASSERT(a_col_in_range, col_r <= LAST_COL, "column cursor out of range")
  `TCCE_ASSERT(a_no_draw_zero,
    !out_valid_r || out_r.draw_valid ||
    (out_r.scroll_lines == 8'd0 && out_r.pixel_column == 7'd0 && out_r.glyph_code == 8'd0),
    "undrawn result carries glyph data")
  `TCCE_ASSERT_NEXT(a_draw_flush, in_fire && is_draw,
    out_valid_r && out_r.draw_valid && pend_r <= 8'd1,
    "pending scrolls not released on draw")

endmodule

### dv/tb_text_console_cursor_engine.sv
// Testbench for text_console_cursor_engine: a directed and a randomized character
// stream, predicted by a scoreboard class and checked field by field.
// Depends on tcce_pkg and the text_console_cursor_engine RTL.

class cursor_scoreboard;
  logic [4:0]  col_pos;
  logic [15:0] row_pos;
  logic        lf_armed;
  logic [7:0]  scroll_backlog;
  logic        cont_mode;
  logic [4:0]  home_col;
  logic [2:0]  home_row;
  tcce_pkg::tcce_out_t expected_results[$];
  int errors;

  function new();
    col_pos = '0;
    row_pos = '0;
    lf_armed = 1'b1;
    scroll_backlog = '0;
    cont_mode = 1'b0;
    home_col = '0;
    home_row = '0;
    errors = 0;
  endfunction

  function int pending();
    return expected_results.size();
  endfunction

  function void write_register(logic [1:0] idx, logic [4:0] data);
    case (idx)
      tcce_pkg::CFG_IDX_CONTINUOUS:   cont_mode = data[0];
      tcce_pkg::CFG_IDX_START_COLUMN: home_col = data;
      tcce_pkg::CFG_IDX_START_ROW:    home_row = data[2:0];
      default: ;
    endcase
  endfunction

  // Moving past the last text row leaves one more line for the next glyph to scroll.
  function void advance_row();
    if (row_pos != 16'hFFFF) row_pos = row_pos + 16'd1;
    if (row_pos > tcce_pkg::TEXT_ROWS_DEF - 1 && scroll_backlog != 8'hFF)
      scroll_backlog = scroll_backlog + 8'd1;
  endfunction

  function void note_request(tcce_pkg::tcce_in_t req);
    tcce_pkg::tcce_out_t res;
    int col_next;
    res = '0;
    if (req.string_start && !cont_mode) begin
      col_pos = (home_col > tcce_pkg::TEXT_COLUMNS_DEF - 1) ?
                5'(tcce_pkg::TEXT_COLUMNS_DEF - 1) : home_col;
      row_pos = 16'(home_row);
    end
    case (req.char_code)
      tcce_pkg::CHAR_NUL: ;
      tcce_pkg::CHAR_CR: col_pos = '0;
      tcce_pkg::CHAR_LF: begin
        if (lf_armed) advance_row();
        lf_armed = 1'b1;
      end
      tcce_pkg::CHAR_TAB: begin
        lf_armed = 1'b1;
        col_next = ((int'(col_pos) >> 2) + 1) << 2;
        if (col_next >= tcce_pkg::TEXT_COLUMNS_DEF - 1) begin
          col_pos = '0;
          advance_row();
        end else begin
          col_pos = 5'(col_next);
        end
      end
      default: begin
        lf_armed = 1'b1;
        res.draw_valid = 1'b1;
        res.scroll_lines = scroll_backlog;
        scroll_backlog = '0;
        res.pixel_column = 7'(int'(col_pos) * tcce_pkg::GLYPH_WIDTH_DEF);
        res.page_row = (row_pos > tcce_pkg::TEXT_ROWS_DEF - 1) ?
                       3'(tcce_pkg::TEXT_ROWS_DEF - 1) : row_pos[2:0];
        res.glyph_code = req.char_code;
        // An automatic wrap already moved down, so the next LF is swallowed.
        if (int'(col_pos) + 1 >= tcce_pkg::TEXT_COLUMNS_DEF) begin
          col_pos = '0;
          lf_armed = 1'b0;
          advance_row();
        end else begin
          col_pos = col_pos + 5'd1;
        end
      end
    endcase
    res.cursor_column = col_pos;
    res.cursor_row = row_pos;
    expected_results.push_back(res);
  endfunction

  task report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  task compare_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
  endtask

  task check_result(tcce_pkg::tcce_out_t got);
    tcce_pkg::tcce_out_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result %p with no request outstanding", got));
    end else begin
      want = expected_results.pop_front();
      compare_field("draw_valid", 16'(got.draw_valid), 16'(want.draw_valid));
      compare_field("scroll_lines", 16'(got.scroll_lines), 16'(want.scroll_lines));
      compare_field("pixel_column", 16'(got.pixel_column), 16'(want.pixel_column));
      compare_field("page_row", 16'(got.page_row), 16'(want.page_row));
      compare_field("glyph_code", 16'(got.glyph_code), 16'(want.glyph_code));
      compare_field("cursor_column", 16'(got.cursor_column), 16'(want.cursor_column));
      compare_field("cursor_row", got.cursor_row, want.cursor_row);
    end
  endtask
endclass

module tb_text_console_cursor_engine;
  import tcce_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 1000;
  localparam int PHASE_REQUESTS = 80;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  tcce_in_t   in_payload;
  logic       out_valid;
  logic       out_ready;
  tcce_out_t  out_payload;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [4:0] cfg_data;

  int send_idle_pct;
  int recv_idle_pct;
  int sent_count;
  cursor_scoreboard board;

  wire any_accept = (in_valid && in_ready) || (out_valid && out_ready) ||
                    (cfg_valid && cfg_ready);

  text_console_cursor_engine dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_payload(in_payload),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_payload(out_payload),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) board.check_result(out_payload);
      if (cfg_valid && cfg_ready) board.write_register(cfg_index, cfg_data);
      if (in_valid && in_ready) board.note_request(in_payload);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || any_accept) quiet = 0;
      else quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_char(logic [7:0] code, logic start);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_payload <= '{char_code: code, string_start: start};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    sent_count++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic apply_setting(logic cont, logic [4:0] col, logic [2:0] row);
    logic [1:0] idx [3];
    logic [4:0] val [3];
    idx = '{CFG_IDX_CONTINUOUS, CFG_IDX_START_COLUMN, CFG_IDX_START_ROW};
    val = '{{4'($urandom), cont}, col, {2'($urandom), row}};
    for (int k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data <= val[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_noise();
    logic [7:0] code;
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) code = CHAR_NUL;
    else if (pick < 25) code = CHAR_CR;
    else if (pick < 45) code = CHAR_LF;
    else if (pick < 60) code = CHAR_TAB;
    else code = 8'($urandom_range(1, 255));
    send_char(code, $urandom_range(4) == 0);
  endtask

  // A text line, long enough at times to wrap, ending in CR LF, LF, CR or nothing.
  task automatic send_line();
    int len;
    int ending;
    len = $urandom_range(0, 30);
    ending = $urandom_range(3);
    for (int i = 0; i < len; i++)
      send_char(($urandom_range(9) == 0) ? CHAR_TAB : 8'($urandom_range(32, 126)),
                i == 0 && $urandom_range(2) == 0);
    if (ending == 0 || ending == 2) send_char(CHAR_CR, 1'b0);
    if (ending <= 1) send_char(CHAR_LF, 1'b0);
  endtask

  task automatic send_random(int count, bit mid_pause);
    int stop_at;
    stop_at = sent_count + count;
    while (sent_count < stop_at) begin
      if ($urandom_range(4) == 0) send_noise();
      else send_line();
      if (mid_pause && sent_count >= stop_at - count / 2) begin
        drain();
        mid_pause = 0;
      end
    end
  endtask

  initial begin
    board = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_payload = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sent_count = 0;
    send_idle_pct = 37;
    recv_idle_pct = 50;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset configuration: an empty string, control codes and code extremes.
    send_char(CHAR_NUL, 1'b1);
    send_char(8'h48, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h01, 1'b0);
    send_char(CHAR_TAB, 1'b0);
    send_char(CHAR_CR, 1'b0);
    send_char(CHAR_LF, 1'b0);
    send_char(CHAR_LF, 1'b0);
    drain();

    // Start in the last column of the last row: wrap, swallowed LF, scrolls.
    apply_setting(1'b0, 5'd20, 3'd7);
    send_char(8'h78, 1'b1);
    send_char(CHAR_LF, 1'b0);
    send_char(CHAR_LF, 1'b0);
    send_char(8'h79, 1'b0);
    send_char(CHAR_TAB, 1'b1);
    send_char(CHAR_NUL, 1'b1);
    send_char(CHAR_TAB, 1'b0);
    drain();

    apply_setting(1'b1, 5'd31, 3'd0);
    send_char(8'h7A, 1'b1);
    send_char(CHAR_TAB, 1'b0);
    drain();

    // A start column beyond the last column is clamped when loaded.
    apply_setting(1'b0, 5'd31, 3'd0);
    send_char(8'h71, 1'b1);
    send_char(CHAR_CR, 1'b1);
    send_char(8'h80, 1'b0);
    send_char(8'h7F, 1'b0);
    drain();

    apply_setting(1'b0, 5'd9, 3'd3);
    send_random(PHASE_REQUESTS, 1'b0);
    drain();

    send_idle_pct = 50;
    recv_idle_pct = 37;
    apply_setting(1'b1, 5'd5, 3'd2);
    send_random(PHASE_REQUESTS, 1'b1);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_setting(1'b0, 5'd0, 3'd7);
    send_random(PHASE_REQUESTS, 1'b0);
    drain();

    // Enough line feeds to saturate the scroll backlog.
    apply_setting(1'b1, 5'd21, 3'd4);
    for (int i = 0; i < 270; i++) send_char(CHAR_LF, $urandom_range(1));
    send_char(8'h5A, 1'b0);
    send_char(CHAR_LF, 1'b0);
    drain();
    apply_setting(1'b0, 5'd31, 3'd5);
    send_char(8'h41, 1'b1);
    send_random(40, 1'b0);

    drain();
    repeat (4) @(negedge clk);
    if (board.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
